FILE: src/pose_to_affine_matrix_macros.svh
// assertion macros for the pose to affine matrix block
`ifndef POSE_TO_AFFINE_MATRIX_MACROS_SVH
`define POSE_TO_AFFINE_MATRIX_MACROS_SVH
`ifndef ASSERT_OFF
`define PAM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PAM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define PAM_ASSERT(lbl, cond, msg)
`define PAM_ASSERT_IMP(lbl, pre, post, msg)
`endif
`endif

FILE: src/pam_pkg.sv
// shared constants, types and functions for the pose to affine matrix block
package pam_pkg;
  localparam int TRIG_STAGES = 24;
  localparam int NSTG = (TRIG_STAGES > 32) ? 32 : TRIG_STAGES;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
  localparam int MUL_STAGES = 3;
  localparam int LAT = NSTG + 2 + MUL_STAGES;

  typedef logic signed [31:0] word_t;
  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t x;
    cw_t y;
    cw_t z;
    logic [1:0] q;
  } cord_t;

  typedef struct packed {
    cord_t a;
    cord_t b;
    cord_t c;
    word_t lx;
    word_t ly;
    word_t lz;
    word_t ou;
    word_t ov;
    word_t ow;
  } cell_t;

  function automatic cw_t atan_ba(input logic [4:0] i);
    case (i)
      5'd0: atan_ba = 34'sh020000000;
      5'd1: atan_ba = 34'sh012E4051E;
      5'd2: atan_ba = 34'sh009FB385B;
      5'd3: atan_ba = 34'sh0051111D4;
      5'd4: atan_ba = 34'sh0028B0D43;
      5'd5: atan_ba = 34'sh00145D7E1;
      5'd6: atan_ba = 34'sh000A2F61E;
      5'd7: atan_ba = 34'sh000517C55;
      5'd8: atan_ba = 34'sh00028BE53;
      5'd9: atan_ba = 34'sh000145F2F;
      5'd10: atan_ba = 34'sh0000A2F98;
      5'd11: atan_ba = 34'sh0000517CC;
      5'd12: atan_ba = 34'sh000028BE6;
      5'd13: atan_ba = 34'sh0000145F3;
      5'd14: atan_ba = 34'sh00000A2FA;
      5'd15: atan_ba = 34'sh00000517D;
      5'd16: atan_ba = 34'sh0000028BE;
      5'd17: atan_ba = 34'sh00000145F;
      5'd18: atan_ba = 34'sh000000A30;
      5'd19: atan_ba = 34'sh000000518;
      5'd20: atan_ba = 34'sh00000028C;
      5'd21: atan_ba = 34'sh000000146;
      5'd22: atan_ba = 34'sh0000000A3;
      5'd23: atan_ba = 34'sh000000051;
      5'd24: atan_ba = 34'sh000000029;
      5'd25: atan_ba = 34'sh000000014;
      5'd26: atan_ba = 34'sh00000000A;
      5'd27: atan_ba = 34'sh000000005;
      5'd28: atan_ba = 34'sh000000003;
      5'd29: atan_ba = 34'sh000000001;
      5'd30: atan_ba = 34'sh000000001;
      default: atan_ba = '0;
    endcase
  endfunction

  function automatic cord_t cord_init(input word_t ang);
    logic [31:0] u;
    cord_t r;
    u = ang + 32'h2000_0000;
    r.q = u[31:30];
    r.x = CORDIC_X0;
    r.y = '0;
    r.z = $signed({4'd0, u[29:0]}) - 34'sd536870912;
    return r;
  endfunction

  function automatic cord_t cord_step(input cord_t c, input logic [4:0] i);
    cord_t r;
    cw_t dx;
    cw_t dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    r.q = c.q;
    if (!c.z[CW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - atan_ba(i);
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + atan_ba(i);
    end
    return r;
  endfunction

  function automatic word_t unit34(input cw_t v);
    if (v > 34'sd1073741824) unit34 = ONE_Q30;
    else if (v < -34'sd1073741824) unit34 = -ONE_Q30;
    else unit34 = v[31:0];
  endfunction

  // q30 product with rounding, 64-bit intermediate
  function automatic cw_t mulq(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    mulq = CW'(p >>> 30);
  endfunction
endpackage

FILE: src/pam_cell.sv
// one cordic stage for three angles, carrying the rest of the pose along
module pam_cell (
  input  logic              clk,
  input  logic              en,
  input  logic [4:0]        idx,
  input  pam_pkg::cell_t    d_in,
  output pam_pkg::cell_t    d_out
);
  import pam_pkg::*;
  cell_t d_r;
  cell_t d_nxt;

  always_comb begin
    d_nxt = d_in;
    d_nxt.a = cord_step(d_in.a, idx);
    d_nxt.b = cord_step(d_in.b, idx);
    d_nxt.c = cord_step(d_in.c, idx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;
endmodule

FILE: src/pam_matrix.sv
// matrix products, tool point sums and saturation after the cordic chain
module pam_matrix (
  input  logic              clk,
  input  logic              en,
  input  pam_pkg::cell_t    d_in,
  output pam_pkg::word_t    m_o [9],
  output pam_pkg::word_t    tip_o [3]
);
  import pam_pkg::*;

  word_t six_r, cox_r, siy_r, coy_r, siz_r, coz_r;
  word_t lx_r, ly_r, lz_r, ou_r, ov_r, ow_r;
  word_t sxsy_r, cxsy_r, s1x_r, c1x_r, s1y_r, c1y_r, s1z_r, c1z_r;
  word_t b1x_r, b1y_r, b1z_r, u1_r, v1_r, w1_r;
  word_t m_r [9];
  word_t md_r [9];
  word_t b2x_r, b2y_r, b2z_r, u2_r, v2_r, w2_r;
  logic signed [65:0] p_r [9];
  word_t b3x_r, b3y_r, b3z_r;
  word_t tip_r [3];

  function automatic void fix(input cord_t c, output word_t s, output word_t co);
    word_t x;
    word_t y;
    x = unit34(c.x);
    y = unit34(c.y);
    case (c.q)
      2'd0: begin co = x; s = y; end
      2'd1: begin co = -y; s = x; end
      2'd2: begin co = -x; s = -y; end
      default: begin co = y; s = -x; end
    endcase
  endfunction

  function automatic word_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  word_t sx, cx, sy, cy, sz, cz;
  always_comb begin
    fix(d_in.a, sx, cx);
    fix(d_in.b, sy, cy);
    fix(d_in.c, sz, cz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      six_r <= sx; cox_r <= cx; siy_r <= sy; coy_r <= cy; siz_r <= sz; coz_r <= cz;
      lx_r <= d_in.lx; ly_r <= d_in.ly; lz_r <= d_in.lz;
      ou_r <= d_in.ou; ov_r <= d_in.ov; ow_r <= d_in.ow;
      // shared products
      sxsy_r <= word_t'(mulq(six_r, siy_r));
      cxsy_r <= word_t'(mulq(cox_r, siy_r));
      s1x_r <= six_r; c1x_r <= cox_r; s1y_r <= siy_r;
      c1y_r <= coy_r; s1z_r <= siz_r; c1z_r <= coz_r;
      b1x_r <= lx_r; b1y_r <= ly_r; b1z_r <= lz_r;
      u1_r <= ou_r; v1_r <= ov_r; w1_r <= ow_r;
      // matrix entries
      m_r[0] <= unit34(mulq(c1y_r, c1z_r));
      m_r[1] <= unit34(mulq(c1y_r, s1z_r));
      m_r[2] <= unit34(-{{2{s1y_r[31]}}, s1y_r});
      m_r[3] <= unit34(mulq(c1z_r, sxsy_r) - mulq(c1x_r, s1z_r));
      m_r[4] <= unit34(mulq(s1z_r, sxsy_r) + mulq(c1x_r, c1z_r));
      m_r[5] <= unit34(mulq(c1y_r, s1x_r));
      m_r[6] <= unit34(mulq(s1x_r, s1z_r) + mulq(c1z_r, cxsy_r));
      m_r[7] <= unit34(mulq(s1z_r, cxsy_r) - mulq(c1z_r, s1x_r));
      m_r[8] <= unit34(mulq(c1x_r, c1y_r));
      b2x_r <= b1x_r; b2y_r <= b1y_r; b2z_r <= b1z_r;
      u2_r <= u1_r; v2_r <= v1_r; w2_r <= w1_r;
      // offset products
      p_r[0] <= 66'(u2_r) * 66'(m_r[0]);
      p_r[1] <= 66'(v2_r) * 66'(m_r[3]);
      p_r[2] <= 66'(w2_r) * 66'(m_r[6]);
      p_r[3] <= 66'(u2_r) * 66'(m_r[1]);
      p_r[4] <= 66'(v2_r) * 66'(m_r[4]);
      p_r[5] <= 66'(w2_r) * 66'(m_r[7]);
      p_r[6] <= 66'(u2_r) * 66'(m_r[2]);
      p_r[7] <= 66'(v2_r) * 66'(m_r[5]);
      p_r[8] <= 66'(w2_r) * 66'(m_r[8]);
      b3x_r <= b2x_r; b3y_r <= b2y_r; b3z_r <= b2z_r;
      md_r <= m_r;
      m_o <= md_r;
      for (int k = 0; k < 3; k++) begin
        tip_r[k] <= sat32(((p_r[3*k] + p_r[3*k+1] + p_r[3*k+2] + 66'sd536870912) >>> 30)
                    + 66'(k == 0 ? b3x_r : (k == 1 ? b3y_r : b3z_r)));
      end
    end
  end

  assign tip_o = tip_r;
endmodule

FILE: src/pose_to_affine_matrix.sv
// Pose to affine transform: one pose per clock while the output is not
// stalled. A pose passes through a chain of TRIG_STAGES cordic cells (24 by
// default), then registered stages of trig fix-up, shared products, matrix
// entries, offset products and tool point sums. The whole pipeline advances
// together when the output is not stalled.
module pose_to_affine_matrix (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pam_pkg::word_t      in_lin_x,
  input  pam_pkg::word_t      in_lin_y,
  input  pam_pkg::word_t      in_lin_z,
  input  pam_pkg::word_t      in_rot_a,
  input  pam_pkg::word_t      in_rot_b,
  input  pam_pkg::word_t      in_rot_c,
  input  pam_pkg::word_t      in_off_u,
  input  pam_pkg::word_t      in_off_v,
  input  pam_pkg::word_t      in_off_w,
  output logic                out_valid,
  input  logic                out_stall,
  output pam_pkg::word_t      out_m00,
  output pam_pkg::word_t      out_m10,
  output pam_pkg::word_t      out_m20,
  output pam_pkg::word_t      out_m01,
  output pam_pkg::word_t      out_m11,
  output pam_pkg::word_t      out_m21,
  output pam_pkg::word_t      out_norm_x,
  output pam_pkg::word_t      out_norm_y,
  output pam_pkg::word_t      out_norm_z,
  output pam_pkg::word_t      out_tip_x,
  output pam_pkg::word_t      out_tip_y,
  output pam_pkg::word_t      out_tip_z
);
  import pam_pkg::*;
  `include "pose_to_affine_matrix_macros.svh"

  logic [LAT-1:0] vld_r;
  logic en;
  cell_t chain [NSTG+1];
  word_t m [9];
  word_t tp [3];

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    chain[0].a = cord_init(in_rot_a);
    chain[0].b = cord_init(in_rot_b);
    chain[0].c = cord_init(in_rot_c);
    chain[0].lx = in_lin_x; chain[0].ly = in_lin_y; chain[0].lz = in_lin_z;
    chain[0].ou = in_off_u; chain[0].ov = in_off_v; chain[0].ow = in_off_w;
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    pam_cell u_cell (.clk(clk), .en(en), .idx(5'(g)), .d_in(chain[g]), .d_out(chain[g+1]));
  end

  pam_matrix u_mat (.clk(clk), .en(en), .d_in(chain[NSTG]), .m_o(m), .tip_o(tp));

  assign out_m00 = m[0]; assign out_m10 = m[1]; assign out_m20 = m[2];
  assign out_m01 = m[3]; assign out_m11 = m[4]; assign out_m21 = m[5];
  assign out_norm_x = m[6]; assign out_norm_y = m[7]; assign out_norm_z = m[8];
  assign out_tip_x = tp[0]; assign out_tip_y = tp[1]; assign out_tip_z = tp[2];

  `PAM_ASSERT(a_stall_only_out, in_stall == (out_valid && out_stall), "stall mismatch")
  `PAM_ASSERT_IMP(a_hold, out_valid && out_stall, out_valid, "result dropped")
  `PAM_ASSERT_IMP(a_shift, en, vld_r[0] == $past(in_valid), "valid chain slip")
endmodule

FILE: sim/tb_pose_to_affine_matrix.sv
// testbench for pose_to_affine_matrix: directed and random poses checked against a cordic predictor
`timescale 1ns / 1ps

module tb_pose_to_affine_matrix;
  import pam_pkg::*;

  localparam int DEPTH = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  word_t in_lin_x = '0, in_lin_y = '0, in_lin_z = '0;
  word_t in_rot_a = '0, in_rot_b = '0, in_rot_c = '0;
  word_t in_off_u = '0, in_off_v = '0, in_off_w = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  word_t out_m00, out_m10, out_m20, out_m01, out_m11, out_m21;
  word_t out_norm_x, out_norm_y, out_norm_z, out_tip_x, out_tip_y, out_tip_z;

  typedef struct {
    longint v[12];
  } pose_result_t;

  pose_result_t expected_poses[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int stall_mode = 0;

  pose_to_affine_matrix DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam longint ATAN_TAB[32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic void angle_trig(word_t ang, output longint sn, output longint cs);
    logic [31:0] u;
    longint x, y, z, dx, dy;
    u = ang + 32'h2000_0000;
    x = 652032874;
    y = 0;
    z = longint'({2'b0, u[29:0]}) - 536870912;
    for (int i = 0; i < TRIG_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    x = clip(x, -64'sd1073741824, 64'sd1073741824);
    y = clip(y, -64'sd1073741824, 64'sd1073741824);
    case (u[31:30])
      2'd0: begin cs = x; sn = y; end
      2'd1: begin cs = -y; sn = x; end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic pose_result_t predict_pose(word_t p[9]);
    pose_result_t r;
    longint six, cox, siy, coy, siz, coz, sxsy, cxsy, s;
    angle_trig(p[3], six, cox);
    angle_trig(p[4], siy, coy);
    angle_trig(p[5], siz, coz);
    sxsy = qmul(six, siy);
    cxsy = qmul(cox, siy);
    r.v[0] = qmul(coy, coz);
    r.v[1] = qmul(coy, siz);
    r.v[2] = -siy;
    r.v[3] = qmul(coz, sxsy) - qmul(cox, siz);
    r.v[4] = qmul(siz, sxsy) + qmul(cox, coz);
    r.v[5] = qmul(coy, six);
    r.v[6] = qmul(six, siz) + qmul(coz, cxsy);
    r.v[7] = qmul(siz, cxsy) - qmul(coz, six);
    r.v[8] = qmul(cox, coy);
    for (int k = 0; k < 9; k++) r.v[k] = clip(r.v[k], -64'sd1073741824, 64'sd1073741824);
    for (int k = 0; k < 3; k++) begin
      s = longint'(p[6]) * r.v[k] + longint'(p[7]) * r.v[k + 3] + longint'(p[8]) * r.v[k + 6];
      s = ((s + 64'sd536870912) >>> 30) + longint'(p[k]);
      r.v[9 + k] = clip(s, -64'sd2147483648, 64'sd2147483647);
    end
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return word_t'($urandom_range(0, 8) << 29);
      3: return word_t'($urandom_range(0, 200)) - 100;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic string field_name(int k);
    string names[12] = '{"m00", "m10", "m20", "m01", "m11", "m21", "norm_x", "norm_y",
                         "norm_z", "tip_x", "tip_y", "tip_z"};
    return names[k];
  endfunction

  task automatic send_pose(word_t p[9]);
    in_valid <= 1'b1;
    {in_lin_x, in_lin_y, in_lin_z, in_rot_a, in_rot_b, in_rot_c, in_off_u, in_off_v,
     in_off_w} <= {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], p[8]};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_poses.push_back(predict_pose(p));
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_sender();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 4)) @(negedge clk);
  endtask

  task automatic send_burst(word_t p[9]);
    send_pose(p);
    if ($urandom_range(0, 5) == 0) idle_sender();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (DEPTH) @(negedge clk);
  endtask

  task automatic test_directed();
    word_t p[9];
    word_t corner[6] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh4000_0000,
                         32'shC000_0000, 32'sh2000_0000};
    for (int i = 0; i < 6; i++) begin
      foreach (p[k]) p[k] = corner[(i + k) % 6];
      send_burst(p);
    end
    for (int i = 0; i < 8; i++) begin
      foreach (p[k]) p[k] = 32'sh0001_0000;
      p[3] = word_t'(i << 29);
      p[4] = word_t'((7 - i) << 29);
      p[5] = word_t'(i << 29) + 1;
      send_burst(p);
    end
    foreach (p[k]) p[k] = 32'sh7FFF_FFFF;
    p[3] = 0; p[4] = 0; p[5] = 0;
    send_burst(p);
    foreach (p[k]) p[k] = 32'sh8000_0000;
    p[3] = 0; p[4] = 0; p[5] = 0;
    send_burst(p);
    drain();
  endtask

  task automatic test_random();
    word_t p[9];
    int n;
    n = 0;
    while (n < 1000) begin
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 40)) begin
        foreach (p[k]) p[k] = rand_word();
        send_pose(p);
        n++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender();
    end
    drain();
  endtask

  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    pose_result_t e;
    word_t got[12];
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_m00, out_m10, out_m20, out_m01, out_m11, out_m21, out_norm_x, out_norm_y,
              out_norm_z, out_tip_x, out_tip_y, out_tip_z};
      if (expected_poses.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = expected_poses.pop_front();
        checked++;
        for (int k = 0; k < 12; k++) begin
          if (got[k] !== word_t'(e.v[k])) begin
            $error("%s expected %0d actual %0d", field_name(k), word_t'(e.v[k]), got[k]);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random();
    $display("covered %0d poses, %0d results checked: angle quadrant edges,", sent, checked);
    $display("full-scale axes and offsets with saturation, random stalls and gaps");
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: pose_to_affine_matrix.f
+incdir+src
src/pam_pkg.sv
src/pam_cell.sv
src/pam_matrix.sv
src/pose_to_affine_matrix.sv
sim/tb_pose_to_affine_matrix.sv
